// ----- sv/chd_pkg.sv -----
// ----------------------------------------------------------------------------
// chd_pkg - compass heading direction package
// Shared widths, codes, angle constants and the tangent table.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int ANGLE_STEPS = 90;
  localparam int IDX_W       = $clog2(ANGLE_STEPS + 1);
  localparam int TAN_W       = 17;
  localparam int DIV_W       = 32;
  localparam int DVS_W       = 16;
  localparam int STEP_W      = $clog2(DIV_W + 1);
  localparam int RATIO_W     = 25;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int ANG_W       = 9;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_Y  = 2'd3;

  localparam logic signed [15:0] OFFSET_X_RST = -16'sd41;
  localparam logic signed [15:0] OFFSET_Y_RST = 16'sd360;
  localparam logic [14:0]        RANGE_X_RST  = 15'd1413;
  localparam logic [14:0]        RANGE_Y_RST  = 15'd1594;

  localparam logic [ANG_W-1:0] DEG_0   = 9'd0;
  localparam logic [ANG_W-1:0] DEG_45  = 9'd45;
  localparam logic [ANG_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANG_W-1:0] DEG_135 = 9'd135;
  localparam logic [ANG_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANG_W-1:0] DEG_225 = 9'd225;
  localparam logic [ANG_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANG_W-1:0] DEG_315 = 9'd315;
  localparam logic [ANG_W-1:0] DEG_360 = 9'd360;

  localparam logic [9:0] RATIO_SCALE = 10'd1000;

  localparam logic [STEP_W-1:0] DIV1_STEPS = STEP_W'(DIV_W);
  localparam logic [STEP_W-1:0] DIV2_STEPS = STEP_W'(RATIO_W);

  typedef enum logic [1:0] {
    DIR_FRONT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_OTHER = 2'd3
  } dir_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // entry i = round(1000 * tan(i + 0.5 deg))
  localparam logic [TAN_W-1:0] TAN_TABLE [ANGLE_STEPS] = '{
    17'd9,     17'd26,    17'd44,    17'd61,    17'd79,
    17'd96,    17'd114,   17'd132,   17'd149,   17'd167,
    17'd185,   17'd203,   17'd222,   17'd240,   17'd259,
    17'd277,   17'd296,   17'd315,   17'd335,   17'd354,
    17'd374,   17'd394,   17'd414,   17'd435,   17'd456,
    17'd477,   17'd499,   17'd521,   17'd543,   17'd566,
    17'd589,   17'd613,   17'd637,   17'd662,   17'd687,
    17'd713,   17'd740,   17'd767,   17'd795,   17'd824,
    17'd854,   17'd885,   17'd916,   17'd949,   17'd983,
    17'd1018,  17'd1054,  17'd1091,  17'd1130,  17'd1171,
    17'd1213,  17'd1257,  17'd1303,  17'd1351,  17'd1402,
    17'd1455,  17'd1511,  17'd1570,  17'd1632,  17'd1698,
    17'd1768,  17'd1842,  17'd1921,  17'd2006,  17'd2097,
    17'd2194,  17'd2300,  17'd2414,  17'd2539,  17'd2675,
    17'd2824,  17'd2989,  17'd3172,  17'd3376,  17'd3606,
    17'd3867,  17'd4165,  17'd4511,  17'd4915,  17'd5396,
    17'd5976,  17'd6691,  17'd7596,  17'd8777,  17'd10385,
    17'd12706, 17'd16350, 17'd22904, 17'd38188, 17'd114589
  };

endpackage

// ----- sv/compass_heading_direction_core.sv -----
// ----------------------------------------------------------------------------
// compass_heading_direction_core - magnetometer heading and relative direction
// Hard-iron correction, y scaling, arctangent lookup and reference tracking.
// ----------------------------------------------------------------------------
// An item carries raw x and y readings with a command and a data-ready flag
// and yields one result. An item without data-ready goes straight to the
// finish state; a valid item with zero corrected x uses the shared serial
// divider only for the y scaling, which runs 32 one-bit steps; any other
// valid item also runs 25 for the tangent ratio, followed by a binary search
// of the tangent table of at most seven steps. The input is not ready while
// an item is in work; a finished result waits in the output register without
// blocking the next item from being accepted, and an item that finishes while
// that register is still full holds until it drains.
module compass_heading_direction_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [chd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [chd_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [31:0]                       s_axis_tdata_i,   // raw_x, raw_y
  input  logic [1:0]                        s_axis_tuser_i,   // command, data_ready
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [23:0]                       m_axis_tdata_o,   // heading, relative_angle,
                                                              // direction
  output logic                              m_axis_tuser_o    // sample_valid
);
  import chd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ABS, ST_DIV1, ST_PREP, ST_DIV2, ST_SRCH, ST_HEAD, ST_FIN
  } state_e;

  state_e state_q;

  logic signed [15:0] ox_q, oy_q;
  logic [14:0]        rgx_q, rgy_q;

  logic               cmd_q, rdy_q, neg_q;
  logic signed [15:0] xc_q, yc_q;
  logic signed [16:0] dy_q;
  logic signed [32:0] prod_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [IDX_W-1:0]   lo_q, hi_q;
  logic [ANG_W-1:0]   head_q, ref_q;
  logic               m_valid_q, m_user_q;
  logic [23:0]        m_data_q;

  logic signed [15:0] raw_x_c, raw_y_c, xc_c, yc_c;
  logic signed [16:0] dy_c;
  logic signed [32:0] prod_c, mag_c;
  logic [DVS_W-1:0]   ax_c, ay_c, rgy_div_c;
  logic [RATIO_W-1:0] ay1000_c;
  logic [IDX_W-1:0]   mid_c;
  logic [ANG_W-1:0]   head_c, rel_c;
  logic [9:0]         sum_c;
  dir_e               dir_c;
  logic               xp_c, yp_c, yn_c;

  div_req_t div_req;
  div_rsp_t div_rsp;

  chd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= OFFSET_X_RST;
      oy_q  <= OFFSET_Y_RST;
      rgx_q <= RANGE_X_RST;
      rgy_q <= RANGE_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET_X: ox_q  <= signed'(cfg_wdata_i);
        REG_OFFSET_Y: oy_q  <= signed'(cfg_wdata_i);
        REG_RANGE_X:  rgx_q <= cfg_wdata_i[14:0];
        REG_RANGE_Y:  rgy_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_x_c   = signed'(s_axis_tdata_i[15:0]);
    raw_y_c   = signed'(s_axis_tdata_i[31:16]);
    xc_c      = raw_x_c - ox_q;
    dy_c      = 17'(raw_y_c) - 17'(oy_q);
    prod_c    = 33'(dy_q) * 33'(signed'({1'b0, rgx_q}));
    mag_c     = prod_q[32] ? -prod_q : prod_q;
    yc_c      = neg_q ? 16'(-div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];
    ax_c      = xc_q[15] ? 16'(-xc_q) : 16'(xc_q);
    ay_c      = yc_q[15] ? 16'(-yc_q) : 16'(yc_q);
    ay1000_c  = RATIO_W'(ay_c) * RATIO_W'(RATIO_SCALE);
    rgy_div_c = (rgy_q == '0) ? DVS_W'(1) : DVS_W'(rgy_q);
    mid_c     = IDX_W'(((IDX_W+1)'(lo_q) + (IDX_W+1)'(hi_q)) >> 1);

    xp_c = !xc_q[15];
    yp_c = !yc_q[15] && (yc_q != '0);
    yn_c = yc_q[15];
    if (lo_q == IDX_W'(ANGLE_STEPS)) begin
      if (xp_c && yp_c)       head_c = DEG_90;
      else if (xp_c && yn_c)  head_c = DEG_270;
      else if (!xp_c && yn_c) head_c = DEG_270;
      else                    head_c = DEG_90;
    end else begin
      if (xp_c && yp_c)       head_c = DEG_180 - ANG_W'(lo_q);
      else if (xp_c && yn_c)  head_c = DEG_180 + ANG_W'(lo_q);
      else if (!xp_c && yn_c) head_c = DEG_360 - ANG_W'(lo_q);
      else                    head_c = ANG_W'(lo_q);
    end

    sum_c = 10'(head_q) + 10'(DEG_360) - 10'(ref_q);
    if (sum_c >= 10'(DEG_360) + 10'(DEG_360)) begin
      rel_c = ANG_W'(sum_c - 10'(DEG_360) - 10'(DEG_360));
    end else if (sum_c >= 10'(DEG_360)) begin
      rel_c = ANG_W'(sum_c - 10'(DEG_360));
    end else begin
      rel_c = ANG_W'(sum_c);
    end
    if (rel_c >= DEG_315 || rel_c < DEG_45) dir_c = DIR_FRONT;
    else if (rel_c < DEG_135)              dir_c = DIR_LEFT;
    else if (rel_c >= DEG_225)             dir_c = DIR_RIGHT;
    else                                   dir_c = DIR_OTHER;

    div_req.start    = (state_q == ST_ABS) || ((state_q == ST_PREP) && (xc_q != '0));
    div_req.dividend = (state_q == ST_ABS) ? mag_c[DIV_W-1:0]
                                           : DIV_W'(ay1000_c) << (DIV_W - RATIO_W);
    div_req.divisor  = (state_q == ST_ABS) ? rgy_div_c : ax_c;
    div_req.steps    = (state_q == ST_ABS) ? DIV1_STEPS : DIV2_STEPS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= 1'b0;
      rdy_q     <= 1'b0;
      neg_q     <= 1'b0;
      xc_q      <= '0;
      yc_q      <= '0;
      dy_q      <= '0;
      prod_q    <= '0;
      ratio_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      head_q    <= '0;
      ref_q     <= '0;
      m_valid_q <= 1'b0;
      m_user_q  <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_axis_tready_i && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cmd_q   <= s_axis_tuser_i[0];
            rdy_q   <= s_axis_tuser_i[1];
            xc_q    <= xc_c;
            dy_q    <= dy_c;
            head_q  <= DEG_0;
            state_q <= s_axis_tuser_i[1] ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_c;
          state_q <= ST_ABS;
        end
        ST_ABS: begin
          neg_q   <= prod_q[32];
          state_q <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_rsp.done) begin
            yc_q    <= yc_c;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (xc_q == '0) begin
            if (yc_q[15])         head_q <= DEG_270;
            else if (yc_q != '0)  head_q <= DEG_90;
            else                  head_q <= DEG_0;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_rsp.done) begin
            ratio_q <= div_rsp.quotient[RATIO_W-1:0];
            lo_q    <= '0;
            hi_q    <= IDX_W'(ANGLE_STEPS);
            state_q <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (lo_q < hi_q) begin
            if (RATIO_W'(TAN_TABLE[mid_c]) >= ratio_q) hi_q <= mid_c;
            else                                        lo_q <= mid_c + 1'b1;
          end else begin
            state_q <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          head_q  <= head_c;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_user_q  <= rdy_q;
            if (!rdy_q) begin
              m_data_q <= '0;
            end else if (cmd_q) begin
              m_data_q <= {4'b0, DIR_FRONT, DEG_0, head_q};
              ref_q    <= head_q;
            end else begin
              m_data_q <= {4'b0, dir_c, rel_c, head_q};
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after taking an item");

  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("invalid sample with nonzero result");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[8:0] <= DEG_360 && m_axis_tdata_o[17:9] < DEG_360)
    else $error("angle out of range");

  a_ref_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_q <= DEG_360)
    else $error("reference heading out of range");

endmodule

// ----- sv/chd_div.sv -----
// ----------------------------------------------------------------------------
// chd_div - serial unsigned divider
// Restoring division, one quotient bit per cycle over a programmable count.
// ----------------------------------------------------------------------------
module chd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chd_pkg::div_req_t req_i,
  output chd_pkg::div_rsp_t rsp_o
);
  import chd_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVS_W-1:0]  rem_q, dvs_q, rem_d;
  logic [DIV_W-1:0]  quo_q;
  logic [DVS_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        quo_q  <= req_i.dividend;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DIV_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
